/* rtl/core/chd_pkg.sv */
// shared types, constants and trig tables for the compass heading pipeline
// no dependencies; imported by every module of the block
package chd_pkg;

  localparam int SEARCH_BITS = 6;
  localparam int TAB_DEPTH   = 2 ** SEARCH_BITS;
  localparam int FRAC_BITS   = 56;
  localparam int HALF_BITS   = FRAC_BITS / 2;
  localparam int PROD_BITS   = 16 + HALF_BITS;
  localparam int SUM_BITS    = 16 + FRAC_BITS;

  localparam logic [SEARCH_BITS-1:0] MAX_OCTANT_DEG = SEARCH_BITS'(44);

  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C234;
  localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  typedef logic [TAB_DEPTH-1:0][FRAC_BITS-1:0] trig_tab_t;

  // how the octant angle maps onto the full circle
  typedef struct packed {
    logic       special;  // base already holds the final heading
    logic [8:0] base;
    logic       sub;      // heading = base - deg, else base + deg
  } map_t;

  typedef struct packed {
    logic [15:0]            p;    // smaller magnitude
    logic [15:0]            q;    // larger magnitude
    logic [SEARCH_BITS-1:0] deg;  // octant degrees found so far
    map_t                   map;
  } item_t;

  // product of two q2.62 values, truncated
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // cos or sin of every whole degree, q0.56, by repeated one degree rotation
  function automatic trig_tab_t build_trig_tab(input logic want_sin);
    trig_tab_t   tab;
    logic [63:0] x, x2, x3, x4, x5, x6, x7, x8;
    logic [63:0] c1, s1, cf, sf, cn, sn;
    x  = PI_Q62 / 64'd180;
    x2 = q62_mul(x, x);
    x3 = q62_mul(x2, x);
    x4 = q62_mul(x3, x);
    x5 = q62_mul(x4, x);
    x6 = q62_mul(x5, x);
    x7 = q62_mul(x6, x);
    x8 = q62_mul(x7, x);
    s1 = x - x3 / 64'd6 + x5 / 64'd120 - x7 / 64'd5040;
    c1 = ONE_Q62 - x2 / 64'd2 + x4 / 64'd24 - x6 / 64'd720 + x8 / 64'd40320;
    cf = ONE_Q62;
    sf = 64'd0;
    for (int f = 0; f < TAB_DEPTH; f++) begin
      tab[f] = want_sin ? sf[61:6] : cf[61:6];
      cn = q62_mul(cf, c1) - q62_mul(sf, s1);
      sn = q62_mul(sf, c1) + q62_mul(cf, s1);
      cf = cn;
      sf = sn;
    end
    return tab;
  endfunction

  localparam trig_tab_t COS_TAB = build_trig_tab(1'b0);
  localparam trig_tab_t SIN_TAB = build_trig_tab(1'b1);

endpackage

/* rtl/core/compass_heading_degrees_top.sv */
// top level of the compass heading pipeline: prep, degree search, fold
// depends on chd_pkg, chd_prep, chd_step, chd_fold
//
// channel   dir  handshake                      payload
// sample    in   sample_valid, sample_stall     field_x[15:0], field_y[15:0] (signed)
// heading   out  heading_valid, heading_stall   heading_deg[8:0], 0 to 359
//
// one request per cycle sustained while heading_stall is low; 1 prep stage, 6 search bits
// of 3 stages each (table lookup, partial products, wide compare), 1 output stage
// the search-bit multiply and 72-bit compare set the stage depth
// rst clears only the valid bits; no tables or memories need filling
// each stage holds while the next one is full and holding, so bubbles close up
// and a stalled heading does not block requests until the pipeline is full
module compass_heading_degrees_top import chd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [15:0] field_x,
  input  logic signed [15:0] field_y,
  output logic               heading_valid,
  input  logic               heading_stall,
  output logic [8:0]         heading_deg
);

  // stage 0 is the prep output, stage SEARCH_BITS feeds the fold
  item_t stage_item  [SEARCH_BITS+1];
  logic  stage_valid [SEARCH_BITS+1];
  logic  stage_ready [SEARCH_BITS+1];
  logic  prep_ready;

  assign sample_stall = !prep_ready;

  // sign fold to one octant, special cases decided up front
  chd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_valid),
    .in_ready  (prep_ready),
    .field_x   (field_x),
    .field_y   (field_y),
    .out_valid (stage_valid[0]),
    .out_ready (stage_ready[0]),
    .out_item  (stage_item[0])
  );

  // binary search for floor of the octant angle, msb first
  for (genvar i = 0; i < SEARCH_BITS; i++) begin : g_search
    chd_step u_step (
      .clk       (clk),
      .rst       (rst),
      .bit_mask  (SEARCH_BITS'(1 << (SEARCH_BITS - 1 - i))),
      .in_valid  (stage_valid[i]),
      .in_ready  (stage_ready[i]),
      .in_item   (stage_item[i]),
      .out_valid (stage_valid[i+1]),
      .out_ready (stage_ready[i+1]),
      .out_item  (stage_item[i+1])
    );
  end

  // quadrant mapping and output register
  chd_fold u_fold (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (stage_valid[SEARCH_BITS]),
    .in_ready    (stage_ready[SEARCH_BITS]),
    .in_item     (stage_item[SEARCH_BITS]),
    .out_valid   (heading_valid),
    .out_stall   (heading_stall),
    .heading_deg (heading_deg)
  );

  // an empty front stage always takes a request
  a_front_open: assert property (@(posedge clk) disable iff (rst)
    !stage_valid[0] |-> !sample_stall)
    else $error("request stalled while front stage empty");

  // the search never lands past the octant edge
  a_octant_range: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[SEARCH_BITS] && !stage_item[SEARCH_BITS].map.special)
      |-> (stage_item[SEARCH_BITS].deg <= MAX_OCTANT_DEG))
    else $error("octant degree out of range");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading_valid |-> (heading_deg <= 9'd359))
    else $error("heading out of range");

  // a taken heading with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (heading_valid && !heading_stall && !stage_valid[SEARCH_BITS]) |=> !heading_valid)
    else $error("heading repeated");

endmodule

/* rtl/core/chd_prep.sv */
// front stage: magnitudes, octant fold and circle mapping of one sample
// depends on chd_pkg
module chd_prep import chd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] field_x,
  input  logic signed [15:0] field_y,
  output logic               out_valid,
  input  logic               out_ready,
  output item_t              out_item
);

  localparam logic [1:0] QUAD_1 = 2'b00;
  localparam logic [1:0] QUAD_2 = 2'b10;
  localparam logic [1:0] QUAD_3 = 2'b11;

  logic        x_neg, y_neg, x_zero, y_zero, swap, en;
  logic [15:0] ax, ay;
  item_t       item_next;
  logic        valid;
  item_t       item;

  assign x_neg  = field_x[15];
  assign y_neg  = field_y[15];
  assign x_zero = (field_x == 16'sd0);
  assign y_zero = (field_y == 16'sd0);
  // -32768 folds to 16'h8000, the full magnitude
  assign ax     = x_neg ? (~$unsigned(field_x) + 16'd1) : $unsigned(field_x);
  assign ay     = y_neg ? (~$unsigned(field_y) + 16'd1) : $unsigned(field_y);
  assign swap   = (ay > ax);

  always_comb begin
    item_next.p           = swap ? ax : ay;
    item_next.q           = swap ? ay : ax;
    item_next.deg         = '0;
    item_next.map.special = 1'b1;
    item_next.map.sub     = 1'b0;
    item_next.map.base    = 9'd0;
    if (y_zero) begin
      item_next.map.base = x_neg ? 9'd180 : 9'd0;
    end else if (x_zero) begin
      item_next.map.base = y_neg ? 9'd270 : 9'd90;
    end else if (ax == ay) begin
      item_next.map.base = x_neg ? (y_neg ? 9'd225 : 9'd135) : (y_neg ? 9'd315 : 9'd45);
    end else begin
      item_next.map.special = 1'b0;
      case ({x_neg, y_neg})
        QUAD_1: begin
          item_next.map.sub  = swap;
          item_next.map.base = swap ? 9'd89 : 9'd0;
        end
        QUAD_2: begin
          item_next.map.sub  = !swap;
          item_next.map.base = swap ? 9'd90 : 9'd179;
        end
        QUAD_3: begin
          item_next.map.sub  = swap;
          item_next.map.base = swap ? 9'd269 : 9'd180;
        end
        default: begin
          item_next.map.sub  = !swap;
          item_next.map.base = swap ? 9'd270 : 9'd359;
        end
      endcase
    end
  end

  assign en       = !valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item <= item_next;
    end
  end

  assign out_valid = valid;
  assign out_item  = item;

endmodule

/* rtl/core/chd_step.sv */
// one bit of the degree search: table lookup, partial products, compare
// depends on chd_pkg (trig tables, item_t)
module chd_step import chd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SEARCH_BITS-1:0] bit_mask,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  item_t                  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output item_t                  out_item
);

  logic                   en1, en2, en3;
  logic                   v1, v2, v3;
  item_t                  item1, item2, item3, item3_next;
  logic [SEARCH_BITS-1:0] cand_next, cand1, cand2;
  logic                   over1, over2, take;
  logic [FRAC_BITS-1:0]   cos1, sin1;
  logic [PROD_BITS-1:0]   pc_hi, pc_lo, ps_hi, ps_lo;
  logic [SUM_BITS-1:0]    lhs, rhs;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign cand_next = in_item.deg | bit_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // lookup of cos and sin for the candidate degree
  always_ff @(posedge clk) begin
    if (en1) begin
      item1 <= in_item;
      cand1 <= cand_next;
      over1 <= (cand_next > MAX_OCTANT_DEG);
      cos1  <= COS_TAB[cand_next];
      sin1  <= SIN_TAB[cand_next];
    end
  end

  // p*cos and q*sin as two half-width partial products each
  always_ff @(posedge clk) begin
    if (en2) begin
      item2 <= item1;
      cand2 <= cand1;
      over2 <= over1;
      pc_hi <= PROD_BITS'(item1.p) * PROD_BITS'(cos1[FRAC_BITS-1:HALF_BITS]);
      pc_lo <= PROD_BITS'(item1.p) * PROD_BITS'(cos1[HALF_BITS-1:0]);
      ps_hi <= PROD_BITS'(item1.q) * PROD_BITS'(sin1[FRAC_BITS-1:HALF_BITS]);
      ps_lo <= PROD_BITS'(item1.q) * PROD_BITS'(sin1[HALF_BITS-1:0]);
    end
  end

  // angle reaches the candidate when p*cos >= q*sin
  assign lhs  = {pc_hi, HALF_BITS'(0)} + SUM_BITS'(pc_lo);
  assign rhs  = {ps_hi, HALF_BITS'(0)} + SUM_BITS'(ps_lo);
  assign take = !over2 && (lhs >= rhs);

  always_comb begin
    item3_next     = item2;
    item3_next.deg = take ? cand2 : item2.deg;
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      item3 <= item3_next;
    end
  end

  assign out_valid = v3;
  assign out_item  = item3;

endmodule

/* rtl/core/chd_fold.sv */
// last stage: octant degrees onto the full circle, output register
// depends on chd_pkg
module chd_fold import chd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] heading_deg
);

  logic       en, valid;
  logic [8:0] deg_ext, heading_next, heading;

  assign deg_ext = 9'(in_item.deg);

  always_comb begin
    if (in_item.map.special) begin
      heading_next = in_item.map.base;
    end else if (in_item.map.sub) begin
      heading_next = in_item.map.base - deg_ext;
    end else begin
      heading_next = in_item.map.base + deg_ext;
    end
  end

  assign en       = !valid || !out_stall;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading <= heading_next;
    end
  end

  assign out_valid   = valid;
  assign heading_deg = heading;

endmodule
